### hdl/rbd_pkg.sv
// Package for the 2x2 box downscaler: field widths, register defaults,
// register indexes and the channel-wise averaging function.
// No dependencies; every other file of the block imports it.
package rbd_pkg;

	// Field widths fixed by the pixel format and the register map.
	localparam int unsigned PIX_W  = 16;
	localparam int unsigned PAIR_W = 2 * PIX_W;
	localparam int unsigned COL_W  = 11;
	localparam int unsigned CFG_W  = 11;

	// Default size of the line store, in pixel pairs.
	localparam int unsigned MAX_PAIRS_DEF = 1024;

	// Register defaults after reset.
	localparam logic             FORMAT_RESET = 1'b1;
	localparam logic [CFG_W-1:0] PAIRS_RESET  = CFG_W'(160);

	// Channel masks that spread a pixel so that green sits in the upper half
	// and red and blue in the lower half, each with two bits of headroom.
	localparam logic [PAIR_W-1:0] SPREAD_565 = 32'h07E0_F81F;
	localparam logic [PAIR_W-1:0] SPREAD_555 = 32'h03E0_7C1F;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		REG_FORMAT_565     = 1'b0,
		REG_PAIRS_PER_LINE = 1'b1
	} cfg_reg_t;

	// Spread one pixel over 32 bits under the given channel mask.
	function automatic logic [PAIR_W-1:0] spread(input logic [PIX_W-1:0] px,
		input logic [PAIR_W-1:0] mask);
		return {px, px} & mask;
	endfunction

	// Floor average of four pixels, per color channel.
	function automatic logic [PIX_W-1:0] average4(input logic [PIX_W-1:0] a,
		input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] c,
		input logic [PIX_W-1:0] d, input logic fmt_565);
		logic [PAIR_W-1:0] mask;
		logic [PAIR_W-1:0] sum_ab;
		logic [PAIR_W-1:0] sum_cd;
		logic [PAIR_W-1:0] sum;
		logic [PAIR_W-1:0] v;
		mask   = fmt_565 ? SPREAD_565 : SPREAD_555;
		sum_ab = spread(a, mask) + spread(b, mask);
		sum_cd = spread(c, mask) + spread(d, mask);
		sum    = sum_ab + sum_cd;
		v      = (sum >> 2) & mask;
		return v[PIX_W-1:0] | v[PAIR_W-1:PIX_W];
	endfunction

endpackage

### hdl/rbd_stream_if.sv
// Valid/ready stream interfaces for the source pixel channel and the
// downscaled pixel channel. Depends on rbd_pkg for the pixel width.
interface rbd_in_if;
	import rbd_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_in;
	logic             frame_start;

	modport source(output valid, output pixel_in, output frame_start, input ready);
	modport sink(input valid, input pixel_in, input frame_start, output ready);
endinterface

interface rbd_out_if;
	import rbd_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_out;
	logic             line_end;

	modport source(output valid, output pixel_out, output line_end, input ready);
	modport sink(input valid, input pixel_out, input line_end, output ready);
endinterface

### hdl/rbd_line_store.sv
// Single-port line store that holds the pixel pairs of the upper row.
// Registered read data; contents are undefined until written. Uses rbd_pkg.
module rbd_line_store #(
	parameter int unsigned DEPTH = rbd_pkg::MAX_PAIRS_DEF,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic                      re,
	input  logic [AW-1:0]             addr,
	input  logic [rbd_pkg::PAIR_W-1:0] wdata,
	output logic [rbd_pkg::PAIR_W-1:0] rdata_s1
);
	import rbd_pkg::*;

	logic [PAIR_W-1:0] mem [DEPTH];

	// Write and read share one address; the block never does both at once.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_s1 <= mem[addr];
		end
	end
endmodule

### hdl/rgb16_box_downscale_2x2_top.sv
// Top level of the 2x2 box downscaler for 16-bit RGB565/RGB555 pixels.
// Depends on rbd_pkg, rbd_stream_if and rbd_line_store.
//
// The block takes one source pixel per clock in raster order and returns one
// pixel per 2x2 block, each color channel the floor of the average of four.
// Pairs of the even row are kept in an on-chip line store of MAX_PAIRS
// entries; a result leaves on the second pixel of each pair in the odd row.
// Throughput is one input pixel per clock as long as the output is not stalled.
// After the pixel that completes its block is accepted, the result passes
// the registered line store read, then the averaging adders into the output
// register, where it becomes visible on the output. The output register decouples
// the two sides, so the input stalls only while a result is held there and
// another one is waiting behind it. frame_start restarts the row and column
// position. The line store needs no clearing after reset. Configuration
// writes must happen only while no result is in flight.
module rgb16_box_downscale_2x2_top #(
	parameter int unsigned MAX_PAIRS = rbd_pkg::MAX_PAIRS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  rbd_pkg::cfg_reg_t        cfg_index,
	input  logic [rbd_pkg::CFG_W-1:0] cfg_wdata,
	rbd_in_if.sink                   in_ch,
	rbd_out_if.source                out_ch
);
	import rbd_pkg::*;

	localparam int unsigned AW   = $clog2(MAX_PAIRS);
	localparam int unsigned MP_W = $clog2(MAX_PAIRS + 1);
	localparam int unsigned LW   = (MP_W > CFG_W) ? MP_W : CFG_W;
	localparam logic [LW-1:0] MAX_PAIRS_L = LW'(MAX_PAIRS);

	// Configuration registers.
	logic             fmt_565_q;
	logic [CFG_W-1:0] pairs_q;

	// Position state.
	logic [COL_W-1:0] column_q;
	logic             row_odd_q;
	logic             phase_q;
	logic [PIX_W-1:0] held_q;

	// Stage 1 and output registers.
	logic              valid_s1;
	logic [PIX_W-1:0]  left_s1;
	logic [PIX_W-1:0]  right_s1;
	logic              line_end_s1;
	logic              fmt_s1;
	logic [PAIR_W-1:0] pair_s1;
	logic              out_valid_q;
	logic [PIX_W-1:0]  pixel_out_q;
	logic              line_end_q;

	logic             in_acc;
	logic             adv_out;
	logic [COL_W-1:0] col_cur;
	logic             row_cur;
	logic             phase_cur;
	logic [LW-1:0]    pairs_ext;
	logic [LW-1:0]    eff_pairs;
	logic [LW-1:0]    last_col;
	logic             at_end;
	logic [COL_W+AW-1:0] col_ext;
	logic [AW-1:0]    addr;
	logic             st_we;
	logic             st_re;

	// Handshakes: the output register moves when empty or taken.
	assign adv_out      = !out_valid_q || out_ch.ready;
	assign in_ch.ready  = !valid_s1 || adv_out;
	assign in_acc       = in_ch.valid && in_ch.ready;
	assign out_ch.valid     = out_valid_q;
	assign out_ch.pixel_out = pixel_out_q;
	assign out_ch.line_end  = line_end_q;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_565_q <= FORMAT_RESET;
			pairs_q   <= PAIRS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FORMAT_565:     fmt_565_q <= cfg_wdata[0];
				REG_PAIRS_PER_LINE: pairs_q   <= cfg_wdata;
				default:            ;
			endcase
		end
	end

	// Effective line length, clamped to one and to the store size.
	always_comb begin
		pairs_ext = LW'(pairs_q);
		eff_pairs = pairs_ext;
		if (pairs_ext == '0) begin
			eff_pairs = LW'(1);
		end else if (pairs_ext > MAX_PAIRS_L) begin
			eff_pairs = MAX_PAIRS_L;
		end
		last_col = eff_pairs - LW'(1);
	end

	// Position as seen by the current pixel, after a frame restart.
	assign col_cur   = in_ch.frame_start ? '0 : column_q;
	assign row_cur   = in_ch.frame_start ? 1'b0 : row_odd_q;
	assign phase_cur = in_ch.frame_start ? 1'b0 : phase_q;
	assign at_end    = LW'(col_cur) >= last_col;

	// The column never exceeds the last entry of the store, so it indexes the store directly.
	assign col_ext = {{AW{1'b0}}, col_cur};
	assign addr    = col_ext[AW-1:0];
	assign st_we   = in_acc && phase_cur && !row_cur;
	assign st_re   = in_acc && phase_cur && row_cur;

	rbd_line_store #(
		.DEPTH(MAX_PAIRS),
		.AW   (AW)
	) u_store (
		.clk     (clk),
		.we      (st_we),
		.re      (st_re),
		.addr    (addr),
		.wdata   ({in_ch.pixel_in, held_q}),
		.rdata_s1(pair_s1)
	);

	// Row and column tracking on every accepted pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q  <= '0;
			row_odd_q <= 1'b0;
			phase_q   <= 1'b0;
		end else if (in_acc) begin
			if (!phase_cur) begin
				column_q  <= col_cur;
				row_odd_q <= row_cur;
				phase_q   <= 1'b1;
			end else begin
				phase_q   <= 1'b0;
				column_q  <= at_end ? '0 : col_cur + COL_W'(1);
				row_odd_q <= row_cur ^ at_end;
			end
		end
	end

	// Left pixel of the pair being collected.
	always_ff @(posedge clk) begin
		if (in_acc && !phase_cur) begin
			held_q <= in_ch.pixel_in;
		end
	end

	// Stage 1 valid: an odd-row pair is complete and its upper pair is read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= st_re;
		end
	end

	// Stage 1 payload: the lower pair, the line end flag and the format.
	always_ff @(posedge clk) begin
		if (st_re) begin
			left_s1     <= held_q;
			right_s1    <= in_ch.pixel_in;
			line_end_s1 <= at_end;
			fmt_s1      <= fmt_565_q;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= valid_s1;
		end
	end

	// Average the four pixels into the output register.
	always_ff @(posedge clk) begin
		if (adv_out && valid_s1) begin
			pixel_out_q <= average4(pair_s1[PIX_W-1:0], pair_s1[PAIR_W-1:PIX_W],
				left_s1, right_s1, fmt_s1);
			line_end_q  <= line_end_s1;
		end
	end
endmodule

### hdl/rbd_checker.sv
// Port-level checks for the 2x2 box downscaler, attached by bind.
// Depends on rbd_pkg and on the ports of rgb16_box_downscale_2x2_top.
module rbd_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      cfg_we,
	input rbd_pkg::cfg_reg_t         cfg_index,
	input logic [rbd_pkg::CFG_W-1:0] cfg_wdata,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [rbd_pkg::PIX_W-1:0] pixel_out,
	input logic                      line_end
);
	import rbd_pkg::*;

	logic fmt_565_q;

	// Shadow of the format register, taken from configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_565_q <= FORMAT_RESET;
		end else if (cfg_we && cfg_index == REG_FORMAT_565) begin
			fmt_565_q <= cfg_wdata[0];
		end
	end

	// A result that is not taken stays on the output unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_out) && $stable(line_end))
		else $error("output transaction changed while stalled");

	// A new result appears only after an accepted input transaction that completed it.
	a_out_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result appeared without a matching input transaction");

	// The input only stalls behind a full, stalled output register.
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled while the output could move");

	// In RGB555 mode the unused top bit of a result is zero.
	a_555_top: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !fmt_565_q |-> !pixel_out[PIX_W-1])
		else $error("RGB555 result has its top bit set");
endmodule

bind rgb16_box_downscale_2x2_top rbd_checker u_rbd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.cfg_we   (cfg_we),
	.cfg_index(cfg_index),
	.cfg_wdata(cfg_wdata),
	.in_valid (in_ch.valid),
	.in_ready (in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.pixel_out(out_ch.pixel_out),
	.line_end (out_ch.line_end)
);

### tb/sv/tb_rgb16_box_downscale_2x2_top.sv
// Self-checking testbench for the 2x2 box downscaler on 16-bit RGB pixels.
// Depends on rbd_pkg, rbd_stream_if and rgb16_box_downscale_2x2_top; the
// expected averages come from a line-store predictor kept in this file.
module tb_rgb16_box_downscale_2x2_top;
	timeunit 1ns;
	timeprecision 1ps;

	import rbd_pkg::*;

	localparam int unsigned LINE_PAIRS  = MAX_PAIRS_DEF;
	localparam int unsigned HALF_PERIOD = 10;
	localparam int unsigned RAND_ITEMS  = 600;
	localparam longint      TIMEOUT_NS  = 64'd20_000_000;
	localparam int unsigned PRINT_MAX   = 30;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             frame_start;
	} src_px_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             line_end;
	} out_px_t;

	// Stall patterns of the receiving side.
	typedef enum logic [1:0] {
		RCV_OPEN,
		RCV_COIN,
		RCV_SLOW,
		RCV_CHOKE
	} rcv_mode_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             cfg_we    = 1'b0;
	cfg_reg_t         cfg_index = REG_FORMAT_565;
	logic [CFG_W-1:0] cfg_wdata = '0;

	logic             src_valid = 1'b0;
	logic [PIX_W-1:0] src_pixel = '0;
	logic             src_fs    = 1'b0;
	logic             rcv_ready = 1'b0;

	rbd_in_if  src_ch ();
	rbd_out_if dst_ch ();

	assign src_ch.valid       = src_valid;
	assign src_ch.pixel_in    = src_pixel;
	assign src_ch.frame_start = src_fs;
	assign dst_ch.ready       = rcv_ready;

	rgb16_box_downscale_2x2_top #(
		.MAX_PAIRS(LINE_PAIRS)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_ch     (src_ch),
		.out_ch    (dst_ch)
	);

	// Source pixels waiting to be sent and averages waiting to come out.
	src_px_t pending_src [$];
	out_px_t awaited_out [$];
	src_px_t src_next;
	out_px_t out_want;

	int unsigned queued_cnt   = 0;
	int unsigned accepted_cnt = 0;
	int unsigned result_cnt   = 0;
	int unsigned err_count    = 0;

	// Sender burst shaping, switched per phase by the stimulus process.
	bit src_idle_on = 1'b0;
	int unsigned burst_left;
	int unsigned gap_left;

	// Receiver stall pattern state.
	rcv_mode_t   rcv_mode;
	int unsigned rcv_tick;
	int unsigned mode_left;

	// Predictor state: register copies, position in the frame and line store.
	logic             shadow_565   = FORMAT_RESET;
	logic [CFG_W-1:0] shadow_pairs = PAIRS_RESET;
	int unsigned      col_pos      = 0;
	logic             odd_row      = 1'b0;
	logic             right_next   = 1'b0;
	logic [PIX_W-1:0] left_px      = '0;
	logic [PAIR_W-1:0] upper_pairs [LINE_PAIRS];

	// Clock generation.
	always begin
		#(HALF_PERIOD) clk = 1'b1;
		#(HALF_PERIOD) clk = 1'b0;
	end

	// Ends a run that hangs.
	initial begin
		#(TIMEOUT_NS);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		err_count++;
		if (err_count <= PRINT_MAX)
			$display("[%0t] %s", $time, msg);
	endtask

	// Line width in pairs as the block applies it.
	function automatic int unsigned eff_pairs(input logic [CFG_W-1:0] p);
		if (p == 0)
			return 1;
		if (p > LINE_PAIRS)
			return LINE_PAIRS;
		return p;
	endfunction

	// Per-channel floor average of four pixels.
	function automatic logic [PIX_W-1:0] box_avg4(input logic [PIX_W-1:0] a,
		input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] c,
		input logic [PIX_W-1:0] d, input logic is_565);
		logic [7:0] rs;
		logic [7:0] gs;
		logic [7:0] bs;
		bs = 8'(a[4:0]) + 8'(b[4:0]) + 8'(c[4:0]) + 8'(d[4:0]);
		if (is_565) begin
			rs = 8'(a[15:11]) + 8'(b[15:11]) + 8'(c[15:11]) + 8'(d[15:11]);
			gs = 8'(a[10:5]) + 8'(b[10:5]) + 8'(c[10:5]) + 8'(d[10:5]);
			return {rs[6:2], gs[7:2], bs[6:2]};
		end
		rs = 8'(a[14:10]) + 8'(b[14:10]) + 8'(c[14:10]) + 8'(d[14:10]);
		gs = 8'(a[9:5]) + 8'(b[9:5]) + 8'(c[9:5]) + 8'(d[9:5]);
		return {1'b0, rs[6:2], gs[6:2], bs[6:2]};
	endfunction

	// Advances the predictor by one accepted source pixel. Even rows fill the
	// line store by pairs; the right pixel of each odd-row pair yields a result.
	task automatic predict_block_avg(input logic [PIX_W-1:0] px, input logic fs);
		int unsigned       last_col;
		logic              at_end;
		logic [PAIR_W-1:0] upper;
		out_px_t           res;
		last_col = eff_pairs(shadow_pairs) - 1;
		if (fs) begin
			col_pos    = 0;
			odd_row    = 1'b0;
			right_next = 1'b0;
		end
		if (!right_next) begin
			left_px    = px;
			right_next = 1'b1;
		end else begin
			right_next = 1'b0;
			at_end     = (col_pos >= last_col);
			if (!odd_row) begin
				upper_pairs[col_pos % LINE_PAIRS] = {px, left_px};
			end else begin
				upper        = upper_pairs[col_pos % LINE_PAIRS];
				res.pixel    = box_avg4(upper[PIX_W-1:0], upper[PAIR_W-1:PIX_W], left_px, px,
					shadow_565);
				res.line_end = at_end;
				awaited_out.push_back(res);
			end
			if (at_end) begin
				col_pos = 0;
				odd_row = ~odd_row;
			end else begin
				col_pos = (col_pos + 1) & 32'h7FF;
			end
		end
	endtask

	// Source driver: sends pending pixels in bursts with random gaps and feeds
	// every accepted transaction to the predictor.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_valid  <= 1'b0;
			src_pixel  <= '0;
			src_fs     <= 1'b0;
			burst_left <= 1;
			gap_left   <= 0;
		end else begin
			if (src_valid && src_ch.ready) begin
				predict_block_avg(src_pixel, src_fs);
				accepted_cnt++;
			end
			if (!src_valid || src_ch.ready) begin
				if (gap_left != 0) begin
					gap_left  <= gap_left - 1;
					src_valid <= 1'b0;
				end else if (pending_src.size() == 0) begin
					src_valid <= 1'b0;
				end else begin
					src_next  = pending_src.pop_front();
					src_valid <= 1'b1;
					src_pixel <= src_next.pixel;
					src_fs    <= src_next.frame_start;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						if (src_idle_on && $urandom_range(0, 3) != 0)
							gap_left <= $urandom_range(1, 8);
						else
							gap_left <= 0;
					end else begin
						burst_left <= burst_left - 1;
					end
				end
			end
		end
	end

	// Result monitor: checks each transaction against the oldest expected
	// average and drives a receiver stall pattern that changes over time.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcv_ready <= 1'b0;
			rcv_mode  <= RCV_OPEN;
			rcv_tick  <= 0;
			mode_left <= 100;
		end else begin
			if (dst_ch.valid && rcv_ready) begin
				result_cnt++;
				if (awaited_out.size() == 0) begin
					report_mismatch($sformatf("unexpected result %0d: pixel_out=%h line_end=%b",
						result_cnt, dst_ch.pixel_out, dst_ch.line_end));
				end else begin
					out_want = awaited_out.pop_front();
					if (dst_ch.pixel_out !== out_want.pixel)
						report_mismatch($sformatf("result %0d: pixel_out=%h, expected %h",
							result_cnt, dst_ch.pixel_out, out_want.pixel));
					if (dst_ch.line_end !== out_want.line_end)
						report_mismatch($sformatf("result %0d: line_end=%b, expected %b",
							result_cnt, dst_ch.line_end, out_want.line_end));
				end
			end
			rcv_tick <= rcv_tick + 1;
			if (mode_left == 0) begin
				rcv_mode  <= rcv_mode_t'($urandom_range(0, 3));
				mode_left <= $urandom_range(50, 300);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (rcv_mode)
				RCV_OPEN: rcv_ready <= 1'b1;
				RCV_COIN: rcv_ready <= 1'($urandom_range(0, 1));
				RCV_SLOW: rcv_ready <= (rcv_tick % 4 == 0);
				default: rcv_ready <= (rcv_tick % 20 >= 12);
			endcase
		end
	end

	// Register write while the block is idle; the copy follows at the same edge.
	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_FORMAT_565: shadow_565 = val[0];
			default: shadow_pairs = val;
		endcase
	endtask

	task automatic push_px(input logic [PIX_W-1:0] px, input logic fs);
		src_px_t item;
		item.pixel       = px;
		item.frame_start = fs;
		pending_src.push_back(item);
		queued_cnt++;
	endtask

	// Mostly random pixels, with channel extremes mixed in.
	function automatic logic [PIX_W-1:0] pick_px();
		if ($urandom_range(0, 7) != 0)
			return PIX_W'($urandom);
		case ($urandom_range(0, 6))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'hF800;
			3: return 16'h07E0;
			4: return 16'h001F;
			5: return 16'h8000;
			default: return 16'h7FFF;
		endcase
	endfunction

	// Queues whole rows at the current width; only the first pixel may carry
	// the frame flag.
	task automatic push_rows(input int unsigned nrows, input bit lead_fs);
		int unsigned row_px;
		row_px = 2 * eff_pairs(shadow_pairs);
		for (int unsigned i = 0; i < nrows * row_px; i++)
			push_px(pick_px(), lead_fs && i == 0);
	endtask

	// Mostly small widths, now and then zero or a few dozen pairs.
	function automatic logic [CFG_W-1:0] pick_width();
		case ($urandom_range(0, 9))
			0: return '0;
			1, 2, 3, 4: return CFG_W'($urandom_range(1, 4));
			5, 6, 7: return CFG_W'($urandom_range(5, 16));
			8: return CFG_W'($urandom_range(17, 48));
			default: return CFG_W'(1);
		endcase
	endfunction

	// Waits until every queued pixel is taken and every expected result has
	// arrived, then lets the pipeline settle before the next register write.
	task automatic settle();
		int unsigned waited;
		waited = 0;
		while (accepted_cnt != queued_cnt)
			@(posedge clk);
		while (awaited_out.size() != 0 && waited < 2000) begin
			@(posedge clk);
			waited++;
		end
		if (awaited_out.size() != 0) begin
			report_mismatch($sformatf("%0d expected results never arrived",
				awaited_out.size()));
			awaited_out.delete();
		end
		repeat (6) @(posedge clk);
	endtask

	// Stimulus: reset values, directed corners, random phases, oversized width.
	initial begin
		int unsigned rand_base;
		int unsigned old_eff;
		int unsigned nframes;
		int unsigned nrows;
		int unsigned noise_len;
		bit          fresh;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Reset register values: one frame of two rows at 160 pairs.
		src_idle_on = 1'b1;
		push_rows(2, 1'b0);
		settle();

		// Width zero behaves as one pair, so four pixels give one result.
		write_reg(REG_PAIRS_PER_LINE, '0);
		write_reg(REG_FORMAT_565, 1'b1);
		src_idle_on = 1'b0;
		push_px(16'hFFFF, 1'b1);
		push_px(16'hFFFF, 1'b0);
		push_px(16'hFFFF, 1'b0);
		push_px(16'hFFFF, 1'b0);
		push_px(16'h0000, 1'b0);
		push_px(16'hF800, 1'b0);
		push_px(16'h07E0, 1'b0);
		push_px(16'h001F, 1'b0);
		// A frame start in the middle of a pair restarts the pair.
		push_px(16'h1234, 1'b0);
		push_px(16'hABCD, 1'b1);
		push_px(16'h5555, 1'b0);
		push_px(16'hAAAA, 1'b0);
		push_px(16'h0F0F, 1'b0);
		push_px(16'hF0F0, 1'b0);
		settle();

		// RGB555 ignores the top input bit and clears it on output.
		write_reg(REG_FORMAT_565, 1'b0);
		push_px(16'hFFFF, 1'b1);
		push_px(16'hFFFF, 1'b0);
		push_px(16'hFFFF, 1'b0);
		push_px(16'hFFFF, 1'b0);
		push_px(16'h8000, 1'b0);
		push_px(16'h7C00, 1'b0);
		push_px(16'h03E0, 1'b0);
		push_px(16'h001F, 1'b0);
		settle();

		// Narrowing the line while the column is already past the new end
		// closes the line at the next pair.
		write_reg(REG_FORMAT_565, 1'b1);
		write_reg(REG_PAIRS_PER_LINE, CFG_W'(4));
		push_rows(1, 1'b1);
		for (int i = 0; i < 4; i++)
			push_px(pick_px(), 1'b0);
		settle();
		write_reg(REG_PAIRS_PER_LINE, CFG_W'(1));
		for (int i = 0; i < 6; i++)
			push_px(pick_px(), 1'b0);
		settle();

		// Random phases: mostly whole frames, sometimes stray pixels and
		// frame starts at odd places. A wider line always starts a new frame
		// so that no line store entry is read before it is written.
		rand_base = queued_cnt;
		while (queued_cnt - rand_base < RAND_ITEMS) begin
			old_eff = eff_pairs(shadow_pairs);
			if ($urandom_range(0, 1) != 0)
				write_reg(REG_FORMAT_565, 1'($urandom_range(0, 1)));
			if ($urandom_range(0, 3) != 0)
				write_reg(REG_PAIRS_PER_LINE, pick_width());
			fresh = (eff_pairs(shadow_pairs) > old_eff) || ($urandom_range(0, 1) != 0);
			src_idle_on = ($urandom_range(0, 3) != 0);
			nframes = $urandom_range(1, 3);
			for (int unsigned f = 0; f < nframes; f++) begin
				nrows = (eff_pairs(shadow_pairs) > 16) ? 2 : 2 * $urandom_range(1, 2);
				if ($urandom_range(0, 7) == 0)
					nrows = 1;
				push_rows(nrows, fresh || f != 0);
			end
			if ($urandom_range(0, 4) == 0) begin
				noise_len = $urandom_range(1, 2 * eff_pairs(shadow_pairs) + 3);
				for (int unsigned i = 0; i < noise_len; i++)
					push_px(pick_px(), 1'($urandom_range(0, 7) == 0));
			end
			settle();
		end

		// A width past the store size on a partial even row, then a narrow
		// width that closes the row at the next pair and a short odd row.
		src_idle_on = 1'b1;
		write_reg(REG_FORMAT_565, 1'b0);
		write_reg(REG_PAIRS_PER_LINE, '1);
		for (int i = 0; i < 42; i++)
			push_px(pick_px(), (i == 0));
		settle();
		write_reg(REG_PAIRS_PER_LINE, CFG_W'(4));
		src_idle_on = 1'b0;
		for (int i = 0; i < 10; i++)
			push_px(pick_px(), 1'b0);
		settle();

		if (err_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
